### src/tpq_pkg.sv
// shared types, constants and codes of the two-queue ecn marking block
package tpq_pkg;

    // defaults of the top-level parameters
    localparam int DEF_QUEUE_DEPTH = 256;
    localparam int DEF_ID_BITS     = 16;

    // fixed field widths
    localparam int BYTES_W    = 14;
    localparam int THRESH_W   = 9;
    localparam int LIMIT_W    = 10;
    localparam int MEAN_W     = 14;
    localparam int THRB_W     = THRESH_W + MEAN_W;
    localparam int OUTCOME_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // register reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(256);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(512);
    localparam logic [MEAN_W-1:0]   MEAN_RESET   = MEAN_W'(1500);
    localparam logic [THRB_W-1:0]   THRB_RESET   = THRB_W'(256 * 1500);

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_CNT_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTE_MODE   = 3'd0,
        CFG_THRESH_Q0   = 3'd1,
        CFG_THRESH_Q1   = 3'd2,
        CFG_TOTAL_LIMIT = 3'd3,
        CFG_MEAN_BYTES  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_ENQUEUED = 3'd0,
        OUT_MARKED   = 3'd1,
        OUT_DROPPED  = 3'd2,
        OUT_DEQUEUED = 3'd3,
        OUT_EMPTY    = 3'd4
    } outcome_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } back_state_t;

    // configuration as seen by the back end
    typedef struct packed {
        logic                byte_mode;
        logic [THRESH_W-1:0] thresh_q0;
        logic [THRESH_W-1:0] thresh_q1;
        logic [LIMIT_W-1:0]  total_limit;
        logic [THRB_W-1:0]   thr_bytes_q0;
        logic [THRB_W-1:0]   thr_bytes_q1;
    } cfg_t;

    // classified command, id travels beside it
    typedef struct packed {
        op_t                op;
        logic               queue_sel;
        logic               ect;
        logic [BYTES_W-1:0] bytes;
    } cmd_ctrl_t;

endpackage

### src/tpq_if.sv
// channel interfaces: ingress items, egress items, configuration writes
interface tpq_in_if #(
    parameter int ID_BITS = tpq_pkg::DEF_ID_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic                         priority_req;
    logic [ID_BITS-1:0]           packet_id;
    logic [tpq_pkg::BYTES_W-1:0]  packet_bytes;
    logic                         ect;

    modport source (output valid, operation, priority_req, packet_id, packet_bytes, ect,
                    input ready);
    modport sink   (input valid, operation, priority_req, packet_id, packet_bytes, ect,
                    output ready);
endinterface

interface tpq_out_if #(
    parameter int ID_BITS = tpq_pkg::DEF_ID_BITS
);
    logic                           valid;
    logic                           ready;
    logic [tpq_pkg::OUTCOME_W-1:0]  outcome;
    logic                           queue_index;
    logic [ID_BITS-1:0]             out_packet_id;
    logic [tpq_pkg::BYTES_W-1:0]    out_packet_bytes;
    logic                           ce_mark;

    modport source (output valid, outcome, queue_index, out_packet_id, out_packet_bytes,
                    ce_mark, input ready);
    modport sink   (input valid, outcome, queue_index, out_packet_id, out_packet_bytes,
                    ce_mark, output ready);
endinterface

interface tpq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tpq_pkg::CFG_IDX_W-1:0]   index;
    logic [tpq_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/tpq_cfg.sv
// configuration registers with precomputed byte thresholds
module tpq_cfg (
    input  logic            clk,
    input  logic            rst_n,
    tpq_cfg_if.sink         cfg,
    output tpq_pkg::cfg_t   cfg_val
);

    logic                            byte_mode_reg;
    logic [tpq_pkg::THRESH_W-1:0]    thresh_q0_reg;
    logic [tpq_pkg::THRESH_W-1:0]    thresh_q1_reg;
    logic [tpq_pkg::LIMIT_W-1:0]     total_limit_reg;
    logic [tpq_pkg::MEAN_W-1:0]      mean_reg;
    logic [tpq_pkg::THRB_W-1:0]      thr_bytes_q0_reg;
    logic [tpq_pkg::THRB_W-1:0]      thr_bytes_q1_reg;
    logic                            wr_en;
    logic [tpq_pkg::THRESH_W-1:0]    wr_thresh;
    logic [tpq_pkg::MEAN_W-1:0]      wr_mean;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;
    assign wr_thresh = cfg.data[tpq_pkg::THRESH_W-1:0];
    assign wr_mean   = cfg.data[tpq_pkg::MEAN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_mode_reg    <= 1'b0;
            thresh_q0_reg    <= tpq_pkg::THRESH_RESET;
            thresh_q1_reg    <= tpq_pkg::THRESH_RESET;
            total_limit_reg  <= tpq_pkg::LIMIT_RESET;
            mean_reg         <= tpq_pkg::MEAN_RESET;
            thr_bytes_q0_reg <= tpq_pkg::THRB_RESET;
            thr_bytes_q1_reg <= tpq_pkg::THRB_RESET;
        end
        else if (wr_en)
        begin
            case (cfg.index)
                tpq_pkg::CFG_BYTE_MODE:
                begin
                    byte_mode_reg <= cfg.data[0];
                end
                tpq_pkg::CFG_THRESH_Q0:
                begin
                    thresh_q0_reg    <= wr_thresh;
                    thr_bytes_q0_reg <= tpq_pkg::THRB_W'(wr_thresh)
                                        * tpq_pkg::THRB_W'(mean_reg);
                end
                tpq_pkg::CFG_THRESH_Q1:
                begin
                    thresh_q1_reg    <= wr_thresh;
                    thr_bytes_q1_reg <= tpq_pkg::THRB_W'(wr_thresh)
                                        * tpq_pkg::THRB_W'(mean_reg);
                end
                tpq_pkg::CFG_TOTAL_LIMIT:
                begin
                    total_limit_reg <= cfg.data[tpq_pkg::LIMIT_W-1:0];
                end
                tpq_pkg::CFG_MEAN_BYTES:
                begin
                    // both byte thresholds follow the new mean size
                    mean_reg         <= wr_mean;
                    thr_bytes_q0_reg <= tpq_pkg::THRB_W'(thresh_q0_reg)
                                        * tpq_pkg::THRB_W'(wr_mean);
                    thr_bytes_q1_reg <= tpq_pkg::THRB_W'(thresh_q1_reg)
                                        * tpq_pkg::THRB_W'(wr_mean);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg_val.byte_mode    = byte_mode_reg;
        cfg_val.thresh_q0    = thresh_q0_reg;
        cfg_val.thresh_q1    = thresh_q1_reg;
        cfg_val.total_limit  = total_limit_reg;
        cfg_val.thr_bytes_q0 = thr_bytes_q0_reg;
        cfg_val.thr_bytes_q1 = thr_bytes_q1_reg;
    end

endmodule

### src/tpq_front.sv
// front end: accepts ingress items, classifies them into a short command queue
module tpq_front #(
    parameter int ID_BITS = tpq_pkg::DEF_ID_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tpq_in_if.sink                ingress,
    output logic                  cmd_valid,
    output tpq_pkg::cmd_ctrl_t    cmd_ctrl,
    output logic [ID_BITS-1:0]    cmd_id,
    input  logic                  cmd_pop
);

    tpq_pkg::cmd_ctrl_t               ctrl_q_reg [tpq_pkg::CMDQ_DEPTH];
    logic [ID_BITS-1:0]               id_q_reg   [tpq_pkg::CMDQ_DEPTH];
    logic [tpq_pkg::CMDQ_PTR_W-1:0]   wr_ptr_reg;
    logic [tpq_pkg::CMDQ_PTR_W-1:0]   rd_ptr_reg;
    logic [tpq_pkg::CMDQ_CNT_W-1:0]   count_reg;
    logic [tpq_pkg::CMDQ_CNT_W-1:0]   count_next;
    logic                             push;
    logic                             pop;
    tpq_pkg::cmd_ctrl_t               new_ctrl;

    assign ingress.ready = (count_reg != tpq_pkg::CMDQ_CNT_W'(tpq_pkg::CMDQ_DEPTH));
    assign push          = ingress.valid && ingress.ready;
    assign pop           = cmd_pop && cmd_valid;

    // classify the item
    always_comb
    begin
        new_ctrl.op        = tpq_pkg::op_t'(ingress.operation);
        new_ctrl.queue_sel = ingress.priority_req;
        new_ctrl.ect       = ingress.ect;
        new_ctrl.bytes     = ingress.packet_bytes;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_q_reg[wr_ptr_reg] <= new_ctrl;
            id_q_reg[wr_ptr_reg]   <= ingress.packet_id;
        end
    end

    assign cmd_valid = (count_reg != '0);
    assign cmd_ctrl  = ctrl_q_reg[rd_ptr_reg];
    assign cmd_id    = id_q_reg[rd_ptr_reg];

endmodule

### src/tpq_back.sv
// back end: queue state, descriptor ram, admission and marking, result register
module tpq_back #(
    parameter int QUEUE_DEPTH = tpq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = tpq_pkg::DEF_ID_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  tpq_pkg::cmd_ctrl_t    cmd_ctrl,
    input  logic [ID_BITS-1:0]    cmd_id,
    output logic                  cmd_pop,
    input  tpq_pkg::cfg_t         cfg_val,
    tpq_out_if.source             egress
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W   = CNT_W + tpq_pkg::BYTES_W;
    localparam int CW      = (CNT_W + 1 > tpq_pkg::LIMIT_W) ? CNT_W + 1 : tpq_pkg::LIMIT_W;
    localparam int BW      = (TOT_W > tpq_pkg::THRB_W) ? TOT_W : tpq_pkg::THRB_W;
    localparam int ENTRY_W = ID_BITS + tpq_pkg::BYTES_W + 1;
    localparam int SLOTS   = 2 ** (PTR_W + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // queue state
    logic [PTR_W-1:0]  head_reg [2];
    logic [PTR_W-1:0]  head_next [2];
    logic [PTR_W-1:0]  tail_reg [2];
    logic [PTR_W-1:0]  tail_next [2];
    logic [CNT_W-1:0]  cnt_reg [2];
    logic [CNT_W-1:0]  cnt_next [2];
    logic [TOT_W-1:0]  tot_reg [2];
    logic [TOT_W-1:0]  tot_next [2];
    tpq_pkg::back_state_t state_reg;
    tpq_pkg::back_state_t state_next;
    logic              src_reg;
    logic              src_next;

    // descriptor ram
    logic [ENTRY_W-1:0]  desc_mem [SLOTS];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                wr_en;
    logic [PTR_W:0]      wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [PTR_W:0]      rd_addr;

    // result register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    tpq_pkg::outcome_t          outcome_reg;
    tpq_pkg::outcome_t          outcome_next;
    logic                       qidx_reg;
    logic                       qidx_next;
    logic [ID_BITS-1:0]         id_reg;
    logic [ID_BITS-1:0]         id_next;
    logic [tpq_pkg::BYTES_W-1:0] bytes_reg;
    logic [tpq_pkg::BYTES_W-1:0] bytes_next;
    logic                       ce_reg;
    logic                       ce_next;
    logic                       load;
    logic                       out_free;

    // decision signals
    logic                          q;
    logic [CNT_W-1:0]              sel_cnt;
    logic [tpq_pkg::THRESH_W-1:0]  sel_thr;
    logic [tpq_pkg::THRB_W-1:0]    sel_thrb;
    logic                          over;
    logic                          room;
    logic                          admit;
    logic                          mark;
    logic [ID_BITS-1:0]            rd_id;
    logic [tpq_pkg::BYTES_W-1:0]   rd_bytes;
    logic                          rd_ce;

    assign out_free = !out_valid_reg || egress.ready;
    assign q        = cmd_ctrl.queue_sel;
    assign sel_cnt  = cnt_reg[q];
    assign sel_thr  = q ? cfg_val.thresh_q1 : cfg_val.thresh_q0;
    assign sel_thrb = q ? cfg_val.thr_bytes_q1 : cfg_val.thr_bytes_q0;

    // count test c + 1 > t is the same as c >= t
    assign over = cfg_val.byte_mode ? (BW'(tot_reg[q]) > BW'(sel_thrb))
                                    : (CW'(sel_cnt) >= CW'(sel_thr));
    assign room = (CW'(cnt_reg[0]) + CW'(cnt_reg[1])) < CW'(cfg_val.total_limit);
    assign admit = (over ? room : 1'b1) && (sel_cnt < FULL_CNT);
    assign mark  = over && cmd_ctrl.ect;

    assign rd_id    = rd_data_reg[ID_BITS-1:0];
    assign rd_bytes = rd_data_reg[ID_BITS +: tpq_pkg::BYTES_W];
    assign rd_ce    = rd_data_reg[ENTRY_W-1];

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        tot_next       = tot_reg;
        state_next     = state_reg;
        src_next       = src_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = {q, tail_reg[q]};
        wr_data        = {mark, cmd_ctrl.bytes, cmd_id};
        rd_en          = 1'b0;
        rd_addr        = {1'b0, head_reg[0]};
        load           = 1'b0;
        outcome_next   = outcome_reg;
        qidx_next      = qidx_reg;
        id_next        = id_reg;
        bytes_next     = bytes_reg;
        ce_next        = ce_reg;

        case (state_reg)
            tpq_pkg::ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_ctrl.op == tpq_pkg::OP_ENQUEUE)
                    begin
                        load       = 1'b1;
                        qidx_next  = q;
                        id_next    = cmd_id;
                        bytes_next = cmd_ctrl.bytes;
                        if (admit)
                        begin
                            wr_en        = 1'b1;
                            tail_next[q] = (tail_reg[q] == LAST_PTR) ? '0 : tail_reg[q] + 1'b1;
                            cnt_next[q]  = cnt_reg[q] + 1'b1;
                            tot_next[q]  = tot_reg[q] + TOT_W'(cmd_ctrl.bytes);
                            outcome_next = mark ? tpq_pkg::OUT_MARKED : tpq_pkg::OUT_ENQUEUED;
                            ce_next      = mark;
                        end
                        else
                        begin
                            outcome_next = tpq_pkg::OUT_DROPPED;
                            ce_next      = 1'b0;
                        end
                    end
                    else if (cnt_reg[0] != '0 || cnt_reg[1] != '0)
                    begin
                        // queue 0 first, result follows once the ram read lands
                        src_next             = (cnt_reg[0] == '0);
                        rd_en                = 1'b1;
                        rd_addr              = {src_next, head_reg[src_next]};
                        head_next[src_next]  = (head_reg[src_next] == LAST_PTR)
                                               ? '0 : head_reg[src_next] + 1'b1;
                        cnt_next[src_next]   = cnt_reg[src_next] - 1'b1;
                        state_next           = tpq_pkg::ST_READ;
                    end
                    else
                    begin
                        load         = 1'b1;
                        outcome_next = tpq_pkg::OUT_EMPTY;
                        qidx_next    = 1'b0;
                        id_next      = '0;
                        bytes_next   = '0;
                        ce_next      = 1'b0;
                    end
                end
            end
            tpq_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    outcome_next  = tpq_pkg::OUT_DEQUEUED;
                    qidx_next     = src_reg;
                    id_next       = rd_id;
                    bytes_next    = rd_bytes;
                    ce_next       = rd_ce;
                    tot_next[src_reg] = (tot_reg[src_reg] >= TOT_W'(rd_bytes))
                                        ? tot_reg[src_reg] - TOT_W'(rd_bytes) : '0;
                    state_next    = tpq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpq_pkg::ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (egress.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '{default: '0};
            tail_reg      <= '{default: '0};
            cnt_reg       <= '{default: '0};
            tot_reg       <= '{default: '0};
            state_reg     <= tpq_pkg::ST_IDLE;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            tot_reg       <= tot_next;
            state_reg     <= state_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        qidx_reg    <= qidx_next;
        id_reg      <= id_next;
        bytes_reg   <= bytes_next;
        ce_reg      <= ce_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            desc_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= desc_mem[rd_addr];
        end
    end

    assign egress.valid            = out_valid_reg;
    assign egress.outcome          = outcome_reg;
    assign egress.queue_index      = qidx_reg;
    assign egress.out_packet_id    = id_reg;
    assign egress.out_packet_bytes = bytes_reg;
    assign egress.ce_mark          = ce_reg;

    // no queue ever holds more than its depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= FULL_CNT && cnt_reg[1] <= FULL_CNT)
        else $error("queue count above depth");

    // an empty result only when both queues are empty
    a_empty_ok: assert property (@(posedge clk) disable iff (!rst_n)
        load && outcome_next == tpq_pkg::OUT_EMPTY |-> cnt_reg[0] == '0 && cnt_reg[1] == '0)
        else $error("empty reported with packets queued");

    // byte total settles to zero with the last packet out
    a_tot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tpq_pkg::ST_IDLE && cnt_reg[0] == '0 |-> tot_reg[0] == '0)
        else $error("queue 0 byte total left over");

    a_tot_zero1: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tpq_pkg::ST_IDLE && cnt_reg[1] == '0 |-> tot_reg[1] == '0)
        else $error("queue 1 byte total left over");

    // the read state is only entered from an issued ram read
    a_read_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == tpq_pkg::ST_READ) |-> $past(rd_en))
        else $error("read state without ram read");

endmodule

### src/two_priority_queue_ecn_mark.sv
// top level of the two strict-priority queue manager with threshold ecn marking
//
//  channel   direction  handshake     payload
//  ingress   in         valid/ready   operation, priority_req, packet_id, packet_bytes, ect
//  egress    out        valid/ready   outcome, queue_index, out_packet_id, out_packet_bytes,
//                                     ce_mark
//  cfg       in         valid/ready   index, data (ready always high)
//
// an enqueue or an empty dequeue is handled in the idle state alone, a dequeue with
//   a packet also passes the read state, for the registered read of the descriptor ram
// items pass the command queue and result register; dequeued packets also the ram read
// reset clears pointers, counts, byte totals and restores register defaults; the
//   descriptor ram needs no clearing pass
// a stalled egress holds its item; the 2-entry command queue keeps ingress open till full
module two_priority_queue_ecn_mark #(
    parameter int QUEUE_DEPTH = tpq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = tpq_pkg::DEF_ID_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    tpq_in_if.sink      ingress,
    tpq_out_if.source   egress,
    tpq_cfg_if.sink     cfg
);

    tpq_pkg::cfg_t        cfg_val;
    tpq_pkg::cmd_ctrl_t   cmd_ctrl;
    logic [ID_BITS-1:0]   cmd_id;
    logic                 cmd_valid;
    logic                 cmd_pop;

    // register file, byte thresholds kept ready as products
    tpq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    // accept and classify items into the command queue
    tpq_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ingress   (ingress),
        .cmd_valid (cmd_valid),
        .cmd_ctrl  (cmd_ctrl),
        .cmd_id    (cmd_id),
        .cmd_pop   (cmd_pop)
    );

    // admission, marking, strict-priority service and the result register
    tpq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ctrl  (cmd_ctrl),
        .cmd_id    (cmd_id),
        .cmd_pop   (cmd_pop),
        .cfg_val   (cfg_val),
        .egress    (egress)
    );

endmodule

### sim/tpq_egress_checker.sv
// checker: predicts each egress item of the two-queue ecn marking block and compares it
module tpq_egress_checker
    import tpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tpq_in_if         ingress,
    tpq_out_if        egress,
    tpq_cfg_if        cfg,
    output int        mismatches,
    output int        outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
    localparam int ID_W        = DEF_ID_BITS;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
        logic               ce;
    } descriptor_t;

    typedef struct {
        outcome_t           outcome;
        logic               queue_index;
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
        logic               ce;
    } egress_item_t;

    descriptor_t  held_q0[$];
    descriptor_t  held_q1[$];
    egress_item_t pending_results[$];
    longint unsigned byte_total[2];

    logic                mode_bytes;
    logic [THRESH_W-1:0] thresh[2];
    logic [LIMIT_W-1:0]  admit_limit;
    logic [MEAN_W-1:0]   mean_bytes;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t checker: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // admission, marking and strict-priority service of one ingress item
    task automatic predict_queue_op(op_t op, logic q, logic [ID_W-1:0] id,
                                    logic [BYTES_W-1:0] bytes, logic ect);
        egress_item_t res;
        descriptor_t  desc;
        int           depth_q;
        bit           over;
        bit           admit;
        logic         mark;
        res.outcome     = OUT_EMPTY;
        res.queue_index = 1'b0;
        res.id          = '0;
        res.bytes       = '0;
        res.ce          = 1'b0;
        if (op == OP_ENQUEUE) begin
            depth_q = q ? held_q1.size() : held_q0.size();
            if (mode_bytes)
                over = byte_total[q] > longint'(thresh[q]) * longint'(mean_bytes);
            else
                over = depth_q + 1 > int'(thresh[q]);
            mark  = 1'b0;
            admit = 1'b1;
            if (over) begin
                admit = (held_q0.size() + held_q1.size()) < int'(admit_limit);
                mark  = ect;
            end
            if (depth_q >= QUEUE_DEPTH)
                admit = 1'b0;
            res.queue_index = q;
            res.id          = id;
            res.bytes       = bytes;
            if (admit) begin
                desc.id    = id;
                desc.bytes = bytes;
                desc.ce    = mark;
                if (q)
                    held_q1.push_back(desc);
                else
                    held_q0.push_back(desc);
                byte_total[q] += bytes;
                res.outcome = mark ? OUT_MARKED : OUT_ENQUEUED;
                res.ce      = mark;
            end
            else begin
                res.outcome = OUT_DROPPED;
            end
        end
        else if (held_q0.size() > 0 || held_q1.size() > 0) begin
            if (held_q0.size() > 0) begin
                desc            = held_q0.pop_front();
                res.queue_index = 1'b0;
            end
            else begin
                desc            = held_q1.pop_front();
                res.queue_index = 1'b1;
            end
            res.outcome = OUT_DEQUEUED;
            res.id      = desc.id;
            res.bytes   = desc.bytes;
            res.ce      = desc.ce;
            if (byte_total[res.queue_index] >= desc.bytes)
                byte_total[res.queue_index] -= desc.bytes;
            else
                byte_total[res.queue_index] = 0;
        end
        pending_results.push_back(res);
    endtask

    task automatic compare_egress();
        egress_item_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("egress item with nothing pending, outcome",
                            32'(egress.outcome), 32'hFFFF_FFFF);
        end
        else begin
            want = pending_results.pop_front();
            if (egress.outcome !== want.outcome)
                report_mismatch("outcome", 32'(egress.outcome), 32'(want.outcome));
            if (egress.queue_index !== want.queue_index)
                report_mismatch("queue_index", 32'(egress.queue_index), 32'(want.queue_index));
            if (egress.out_packet_id !== want.id)
                report_mismatch("out_packet_id", 32'(egress.out_packet_id), 32'(want.id));
            if (egress.out_packet_bytes !== want.bytes)
                report_mismatch("out_packet_bytes", 32'(egress.out_packet_bytes),
                                32'(want.bytes));
            if (egress.ce_mark !== want.ce)
                report_mismatch("ce_mark", 32'(egress.ce_mark), 32'(want.ce));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_q0.delete();
            held_q1.delete();
            pending_results.delete();
            byte_total[0] = 0;
            byte_total[1] = 0;
            mode_bytes    = 1'b0;
            thresh[0]     = THRESH_RESET;
            thresh[1]     = THRESH_RESET;
            admit_limit   = LIMIT_RESET;
            mean_bytes    = MEAN_RESET;
            mismatches    = 0;
            outstanding  <= 0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_BYTE_MODE:   mode_bytes  = cfg.data[0];
                    CFG_THRESH_Q0:   thresh[0]   = cfg.data[THRESH_W-1:0];
                    CFG_THRESH_Q1:   thresh[1]   = cfg.data[THRESH_W-1:0];
                    CFG_TOTAL_LIMIT: admit_limit = cfg.data[LIMIT_W-1:0];
                    CFG_MEAN_BYTES:  mean_bytes  = cfg.data[MEAN_W-1:0];
                    default: ;
                endcase
            end
            if (egress.valid && egress.ready)
                compare_egress();
            if (ingress.valid && ingress.ready)
                predict_queue_op(op_t'(ingress.operation), ingress.priority_req,
                                 ingress.packet_id, ingress.packet_bytes, ingress.ect);
            outstanding <= pending_results.size();
        end
    end

endmodule

### sim/tb_top.sv
// testbench top: clock, reset, stimulus phases and verdict for the two-queue ecn marking block
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import tpq_pkg::*;

    // an index that names no register, the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    // cycles without any accepted item before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // extra wait after the last egress item has come back
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;

    // sender burst state: items left in the current burst
    int burst_left = 4;

    tpq_in_if  ingress_ch ();
    tpq_out_if egress_ch ();
    tpq_cfg_if cfg_ch ();

    two_priority_queue_ecn_mark DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .ingress (ingress_ch),
        .egress  (egress_ch),
        .cfg     (cfg_ch)
    );

    tpq_egress_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .ingress     (ingress_ch),
        .egress      (egress_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: any accepted item on any channel restarts the count
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((ingress_ch.valid && ingress_ch.ready) || (egress_ch.valid && egress_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // egress back-pressure: the stall style is redrawn periodically so that stalls
    // land on every phase of the block's work, with stretches of no stall at all
    initial
    begin
        int cycle_no;
        int stall_style;
        int stall_run;
        cycle_no    = 0;
        stall_style = 0;
        stall_run   = 0;
        egress_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cycle_no % 128 == 0)
                stall_style = $urandom_range(0, 3);
            cycle_no++;
            case (stall_style)
                0: egress_ch.ready <= 1'b1;
                1: egress_ch.ready <= ($urandom_range(0, 99) >= 30);
                2:
                begin
                    // long stall runs now and then
                    if (stall_run == 0 && $urandom_range(0, 99) < 10)
                        stall_run = $urandom_range(1, 10);
                    egress_ch.ready <= (stall_run == 0);
                    if (stall_run > 0)
                        stall_run--;
                end
                default: egress_ch.ready <= (cycle_no % 4 != 0);
            endcase
        end
    end

    // write all five registers back to back, valid stays high between writes
    task automatic program_registers(bit mode, int t0, int t1, int limit, int mean);
        cfg_reg_t idx[5];
        int       val[5];
        idx = '{CFG_BYTE_MODE, CFG_THRESH_Q0, CFG_THRESH_Q1, CFG_TOTAL_LIMIT, CFG_MEAN_BYTES};
        val = '{int'(mode), t0, t1, limit, mean};
        for (int i = 0; i < 5; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i][CFG_DATA_W-1:0];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // present one item, wait for its handshake, then maybe open a gap after the burst
    task automatic offer_descriptor_op(op_t op, logic q, logic [DEF_ID_BITS-1:0] id,
                                       logic [BYTES_W-1:0] bytes, logic ect);
        int gap;
        ingress_ch.valid        <= 1'b1;
        ingress_ch.operation    <= op;
        ingress_ch.priority_req <= q;
        ingress_ch.packet_id    <= id;
        ingress_ch.packet_bytes <= bytes;
        ingress_ch.ect          <= ect;
        @(posedge clk);
        while (!ingress_ch.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            // about a third of the bursts run straight into the next one
            gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                ingress_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // stop sending and wait until every egress item has come back
    task automatic drain_and_settle();
        ingress_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sizes lean toward the edges so byte-mode thresholds are crossed both ways
    function automatic logic [BYTES_W-1:0] pick_bytes();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return BYTES_W'($urandom_range(0, 15));
        else if (sel < 35)
            return {BYTES_W{1'b1}};
        else
            return BYTES_W'($urandom_range(0, (1 << BYTES_W) - 1));
    endfunction

    // one random phase: set the registers, then a mix of enqueues and dequeues
    task automatic run_phase(bit mode, int t0, int t1, int limit, int mean,
                             int n_items, int enq_pct, int q1_pct);
        op_t op;
        program_registers(mode, t0, t1, limit, mean);
        for (int i = 0; i < n_items; i++)
        begin
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            offer_descriptor_op(op, ($urandom_range(0, 99) < q1_pct),
                                DEF_ID_BITS'($urandom_range(0, 65535)), pick_bytes(),
                                1'($urandom_range(0, 1)));
        end
        drain_and_settle();
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        ingress_ch.valid        <= 1'b0;
        ingress_ch.operation    <= OP_ENQUEUE;
        ingress_ch.priority_req <= 1'b0;
        ingress_ch.packet_id    <= '0;
        ingress_ch.packet_bytes <= '0;
        ingress_ch.ect          <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= CFG_BYTE_MODE;
        cfg_ch.data             <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, count mode: empty dequeue, field extremes, priority order
        offer_descriptor_op(OP_DEQUEUE, 1'b1, 16'hFFFF, 14'h3FFF, 1'b1);
        offer_descriptor_op(OP_ENQUEUE, 1'b0, 16'h0000, 14'h0000, 1'b0);
        offer_descriptor_op(OP_ENQUEUE, 1'b1, 16'hFFFF, 14'h3FFF, 1'b1);
        offer_descriptor_op(OP_ENQUEUE, 1'b1, 16'h1234, 14'h0001, 1'b0);
        offer_descriptor_op(OP_ENQUEUE, 1'b0, 16'hA5A5, 14'h3FFF, 1'b1);
        repeat (4) offer_descriptor_op(OP_DEQUEUE, 1'b0, 16'h0000, 14'h0000, 1'b0);
        offer_descriptor_op(OP_DEQUEUE, 1'b0, 16'h5A5A, 14'h2AAA, 1'b0);
        drain_and_settle();

        // a write to an index with no register must change nothing
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_UNUSED_INDEX;
        cfg_ch.data  <= 14'h0001;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);

        // zero threshold on queue 0, threshold one on queue 1, total limit one:
        // over-threshold marking, the limit drop, under-threshold admission,
        // and a dropped ecn-capable packet carrying no mark
        program_registers(1'b0, 0, 1, 1, 1500);
        offer_descriptor_op(OP_ENQUEUE, 1'b0, 16'h0101, 14'h0010, 1'b1);
        offer_descriptor_op(OP_ENQUEUE, 1'b0, 16'h0202, 14'h0020, 1'b0);
        offer_descriptor_op(OP_ENQUEUE, 1'b1, 16'h0303, 14'h0030, 1'b1);
        offer_descriptor_op(OP_ENQUEUE, 1'b1, 16'h0404, 14'h0040, 1'b1);
        offer_descriptor_op(OP_ENQUEUE, 1'b1, 16'h0505, 14'h0050, 1'b0);
        repeat (3) offer_descriptor_op(OP_DEQUEUE, 1'b1, 16'h0000, 14'h0000, 1'b1);
        drain_and_settle();

        // byte mode with a mean size of one: totals compared against tiny thresholds
        program_registers(1'b1, 1, 0, 512, 1);
        offer_descriptor_op(OP_ENQUEUE, 1'b0, 16'h1111, 14'd5, 1'b1);
        offer_descriptor_op(OP_ENQUEUE, 1'b0, 16'h2222, 14'd7, 1'b1);
        offer_descriptor_op(OP_ENQUEUE, 1'b1, 16'h3333, 14'd0, 1'b1);
        offer_descriptor_op(OP_ENQUEUE, 1'b1, 16'h4444, 14'd9, 1'b0);
        offer_descriptor_op(OP_ENQUEUE, 1'b1, 16'h5555, 14'd3, 1'b1);
        drain_and_settle();

        // random part; the first phase is enqueue-heavy on queue 0 until it is full,
        // the second is dequeue-heavy and works it down, later ones sweep the register extremes
        run_phase(1'b0, 256, 256, 512, 1500, 330, 97, 5);
        run_phase(1'b0, 4, 8, 20, 1500, 260, 15, 50);
        run_phase(1'b1, 2, 0, 300, 16383, 130, 60, 50);
        run_phase(1'b1, 511, 3, 1023, 1, 130, 55, 40);
        // zero mean size: only packets into an empty byte total get in
        run_phase(1'b1, 10, 10, 0, 0, 110, 50, 50);
        run_phase(1'b0, 0, 511, 1023, 16383, 130, 55, 50);
        // small queues, dequeues often find both empty
        run_phase(1'b0, 3, 2, 6, 1, 110, 55, 50);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
